/* hw/rtl/sorted_insert_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted insert priority queue
// Concurrent assertion shorthands sampled on i_clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SIQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("siq assertion failed");

// Next-cycle implication.
`define SIQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("siq assertion failed");

`endif

/* hw/rtl/siq_pkg.sv */
// ----------------------------------------------------------------------------
// siq_pkg
// Types and constants shared by the sorted insert priority queue modules.
// ----------------------------------------------------------------------------
package siq_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int RESULT_W    = 40;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic               ins;
        logic               del;
        t_data              value;
        logic [CNT_W-1:0]   count;
    } t_cell_ctrl;

    // Result transaction, head_value in the lowest bits.
    typedef struct packed {
        t_err                     error_code;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     is_empty;
        logic [VALUE_W-1:0]       head_value;
    } t_result;

endpackage

/* hw/rtl/siq_cell.sv */
// ----------------------------------------------------------------------------
// siq_cell
// One slot of the sorted shift register: compares its entry with the
// broadcast value, then keeps, takes the new value or shifts a neighbor in.
// ----------------------------------------------------------------------------
module siq_cell (
    input  logic                         i_clk,
    input  siq_pkg::t_cell_ctrl          i_ctrl,
    input  logic [siq_pkg::CNT_W-1:0]    i_index,
    input  siq_pkg::t_data               i_prev_data,
    input  logic                         i_prev_keep,
    input  siq_pkg::t_data               i_next_data,
    output siq_pkg::t_data               o_data,
    output logic                         o_keep
);

    siq_pkg::t_data r_data;
    siq_pkg::t_data n_data;

    // Entry stays put when it is live and not smaller than the new value.
    assign o_keep = (i_index < i_ctrl.count) && (r_data >= i_ctrl.value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (!o_keep) begin
                // First slot that gives way takes the value, the rest shift down.
                n_data = i_prev_keep ? i_ctrl.value : i_prev_data;
            end
        end else if (i_ctrl.del) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* hw/rtl/sorted_insert_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded max-priority queue built from a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One transaction per clock: every cell compares its entry with the incoming
// value in the same cycle and the chain shifts in one step, so an enqueue or
// dequeue is applied at once and its registered result transaction reaches
// the master side in the cycle after acceptance. The slave side stalls only
// while a finished result waits in the output register and the master side
// is not ready. tuser carries the action (0 enqueue, 1 dequeue); equal values
// leave in arrival order; enqueue on a full queue and dequeue on an empty
// one leave the contents unchanged and are reported in error_code.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [siq_pkg::VALUE_W-1:0]   i_s_axis_tdata,   // [31:0] value
    input  logic                          i_s_axis_tuser,   // [0] action
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [31:0] head_value, [32] is_empty, [37:33] entry_count, [39:38] error_code
    output logic [siq_pkg::RESULT_W-1:0]  o_m_axis_tdata
);

    localparam int CAP = siq_pkg::CAPACITY;

    logic [siq_pkg::CNT_W-1:0] r_count;
    logic [siq_pkg::CNT_W-1:0] n_count;
    logic                      r_out_valid;
    siq_pkg::t_result          r_result;
    siq_pkg::t_result          n_result;

    siq_pkg::t_cell_ctrl       w_ctrl;
    siq_pkg::t_data            w_value;
    siq_pkg::t_data            w_head;
    siq_pkg::t_action          w_action;
    siq_pkg::t_err             w_err;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;

    siq_pkg::t_data            w_data      [CAP];
    siq_pkg::t_data            w_prev_data [CAP];
    siq_pkg::t_data            w_next_data [CAP];
    logic                      w_keep      [CAP];
    logic                      w_prev_keep [CAP];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_action        = siq_pkg::t_action'(i_s_axis_tuser);
    assign w_value         = siq_pkg::DATA_WIDTH'(64'(signed'(i_s_axis_tdata)));
    assign w_full          = (r_count == siq_pkg::CNT_W'(CAP));
    assign w_empty         = (r_count == '0);

    assign w_ctrl.ins   = w_accept && (w_action == siq_pkg::ACT_ENQUEUE) && !w_full;
    assign w_ctrl.del   = w_accept && (w_action == siq_pkg::ACT_DEQUEUE) && !w_empty;
    assign w_ctrl.value = w_value;
    assign w_ctrl.count = r_count;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev_data[g] = w_value;
                assign w_prev_keep[g] = 1'b1;
            end else begin : g_inner
                assign w_prev_data[g] = w_data[g-1];
                assign w_prev_keep[g] = w_keep[g-1];
            end
            if (g == CAP - 1) begin : g_last
                assign w_next_data[g] = '0;
            end else begin : g_body
                assign w_next_data[g] = w_data[g+1];
            end

            siq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_index     (siq_pkg::CNT_W'(g)),
                .i_prev_data (w_prev_data[g]),
                .i_prev_keep (w_prev_keep[g]),
                .i_next_data (w_next_data[g]),
                .o_data      (w_data[g]),
                .o_keep      (w_keep[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.del) begin
            n_count = r_count - 1'b1;
        end
    end

    // Head after this step, mirroring what cell 0 loads.
    always_comb begin
        w_head = w_data[0];
        if (w_ctrl.ins) begin
            w_head = w_keep[0] ? w_data[0] : w_value;
        end else if (w_ctrl.del) begin
            w_head = w_data[1];
        end
    end

    always_comb begin
        w_err = siq_pkg::ERR_OK;
        if (w_action == siq_pkg::ACT_ENQUEUE && w_full) begin
            w_err = siq_pkg::ERR_FULL;
        end else if (w_action == siq_pkg::ACT_DEQUEUE && w_empty) begin
            w_err = siq_pkg::ERR_EMPTY;
        end
    end

    always_comb begin
        n_result.error_code  = w_err;
        n_result.entry_count = siq_pkg::COUNT_OUT_W'(n_count);
        n_result.is_empty    = (n_count == '0);
        n_result.head_value  = (n_count == '0) ? '0
                             : siq_pkg::VALUE_W'(64'(w_head));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

endmodule

/* hw/rtl/siq_checker.sv */
// ----------------------------------------------------------------------------
// siq_checker
// Port-level checks on the result stream of the priority queue.
// ----------------------------------------------------------------------------
`include "sorted_insert_priority_queue_assert.svh"

module siq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [siq_pkg::RESULT_W-1:0]  o_m_axis_tdata
);

    siq_pkg::t_result                 w_res;
    logic [siq_pkg::COUNT_OUT_W-1:0]  w_cap;
    logic                             w_cnt_zero;
    logic                             w_full_err;
    logic                             w_stall;

    assign w_res      = o_m_axis_tdata;
    assign w_cap      = siq_pkg::COUNT_OUT_W'(siq_pkg::CAPACITY);
    assign w_cnt_zero = (w_res.entry_count == '0);
    assign w_full_err = o_m_axis_tvalid && (w_res.error_code == siq_pkg::ERR_FULL);
    assign w_stall    = o_m_axis_tvalid && !i_m_axis_tready;

    `SIQ_ASSERT_NOW(a_empty_matches_count, o_m_axis_tvalid, w_res.is_empty == w_cnt_zero)
    `SIQ_ASSERT_NOW(a_empty_head_zero, o_m_axis_tvalid && w_res.is_empty, w_res.head_value == '0)
    `SIQ_ASSERT_NOW(a_count_bound, o_m_axis_tvalid, w_res.entry_count <= w_cap)
    `SIQ_ASSERT_NOW(a_full_err_count, w_full_err, w_res.entry_count == w_cap)
    `SIQ_ASSERT_NEXT(a_stall_hold, w_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind sorted_insert_priority_queue siq_checker u_siq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
